// ===== src/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

  localparam int unsigned MaxEntriesDefault = 16;

  // capacity register
  localparam int unsigned CapWidth   = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;
  localparam int unsigned ApbAddrWidth = 3;
  localparam logic [0:0] RegCapacity = 1'b0;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned ValWidth = 31;

  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [KeyWidth-1:0] key;
    logic [ValWidth-1:0] value;
  } lkv_req_t;

  typedef struct packed {
    logic                found;
    logic [ValWidth-1:0] read_value;
  } lkv_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the incoming request
    logic compare;  // match all slots against the request key
    logic update;   // reorder slots and write the response register
  } lkv_cmd_t;

endpackage

`default_nettype wire

// ===== src/lkv_ctrl.sv =====
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lkv_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_finish;
  logic       accept;

  // the response register must be free (or emptying) before it is overwritten
  assign can_finish = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.update  = (state_q == S_UPD) && can_finish;
    cmd_o.compare = (state_q == S_CMP);
    in_stall_o    = !((state_q == S_IDLE) || cmd_o.update);
    accept        = in_valid_i && !in_stall_o;
    cmd_o.load    = accept;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (can_finish) state_d = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.update) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/lkv_dp.sv =====
`default_nettype none

module lkv_dp
  import lkv_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDefault,
  localparam int unsigned CntWidth  = $clog2(MaxEntries + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lkv_cmd_t            cmd_i,
  input  wire lkv_req_t            in_req_i,
  input  wire logic [CntWidth-1:0] eff_cap_i,
  output lkv_rsp_t                 out_rsp_o
);

  lkv_req_t            req_q;
  lkv_rsp_t            rsp_q;
  logic [KeyWidth-1:0] slot_key_q [MaxEntries];
  logic [ValWidth-1:0] slot_val_q [MaxEntries];
  logic [MaxEntries-1:0] slot_vld_q;
  logic [MaxEntries-1:0] match_q;
  logic [MaxEntries-1:0] in_cap;
  logic [MaxEntries-1:0] hit_oh;
  logic [MaxEntries-1:0] shift_mask;
  logic                  found;
  logic                  write_en;
  logic [ValWidth-1:0]   hit_val;
  logic [ValWidth-1:0]   new_val;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cap
    assign in_cap[i] = CntWidth'(i) < eff_cap_i;
  end

  // lowest matching slot is the most recent copy
  assign hit_oh = match_q & (~match_q + MaxEntries'(1));
  assign found  = |match_q;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_val = hit_val | (slot_val_q[i] & {ValWidth{hit_oh[i]}});
    end
  end

  // hit: slots 1..hit move up; new key: slots 1..cap-1 move up, last one drops
  assign shift_mask = found ? (hit_oh | (hit_oh - MaxEntries'(1))) : in_cap;
  assign write_en   = found || (req_q.cmd == CmdPut);
  assign new_val    = (req_q.cmd == CmdPut) ? req_q.value : hit_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
    if (cmd_i.update) begin
      rsp_q.found      <= found;
      rsp_q.read_value <= (found && (req_q.cmd == CmdGet)) ? hit_val : '0;
    end
  end

  for (genvar i = 0; i < MaxEntries; i++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (cmd_i.compare) begin
        match_q[i] <= slot_vld_q[i] && in_cap[i] && (slot_key_q[i] == req_q.key);
      end
    end

    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (cmd_i.update && write_en) begin
          slot_key_q[i] <= req_q.key;
          slot_val_q[i] <= new_val;
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          slot_vld_q[i] <= 1'b0;
        end else if (cmd_i.compare) begin
          slot_vld_q[i] <= slot_vld_q[i] & in_cap[i];
        end else if (cmd_i.update && write_en) begin
          slot_vld_q[i] <= 1'b1;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (cmd_i.update && write_en && shift_mask[i]) begin
          slot_key_q[i] <= slot_key_q[i-1];
          slot_val_q[i] <= slot_val_q[i-1];
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          slot_vld_q[i] <= 1'b0;
        end else if (cmd_i.compare) begin
          // entries past a lowered capacity are dropped
          slot_vld_q[i] <= slot_vld_q[i] & in_cap[i];
        end else if (cmd_i.update && write_en && shift_mask[i]) begin
          slot_vld_q[i] <= slot_vld_q[i-1];
        end
      end
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== src/lru_key_value_cache.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  in_req_i  (cmd, key, value)
// out       source     out_valid_o/out_stall_i out_rsp_o (found, read_value)
// cfg       APB slave  psel/penable/pwrite    paddr, pwdata, prdata
//
// Each request has a compare cycle, which matches the key against every slot in
// parallel, and a shift cycle, which picks the most recent hit and shifts the slots into order.
// A new request is taken in the shift cycle, while the last one finishes.
// The response sits in an output register; a stalled output holds the shift
// cycle until the register drains. Reset empties all slots at once.

module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire lkv_req_t                in_req_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output lkv_rsp_t                     out_rsp_o,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned CntWidth = $clog2(MaxEntries + 1);

  logic [CapWidth-1:0] capacity_q;
  logic [CntWidth-1:0] eff_cap;
  logic                reg_sel;
  lkv_cmd_t            cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegCapacity);
  assign prdata  = reg_sel ? 32'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity_q <= pwdata[CapWidth-1:0];
    end
  end

  // zero acts as one; anything above the slot count saturates
  always_comb begin
    priority if (capacity_q == '0) begin
      eff_cap = CntWidth'(1);
    end else if (32'(capacity_q) > 32'(MaxEntries)) begin
      eff_cap = CntWidth'(MaxEntries);
    end else begin
      eff_cap = CntWidth'(capacity_q);
    end
  end

  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lkv_dp #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .eff_cap_i (eff_cap),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== dv/lru_key_value_cache_test.sv =====
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned PhaseItems = 68;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned RegUnused  = 1;  // index past the register list
  localparam int unsigned PoolMax    = 24;

  // Shadow copy of the cache: predicts each response in request order.
  class lru_shadow;
    logic [CapWidth-1:0] capacity;
    logic [KeyWidth-1:0] slot_key[MaxEntriesDefault];
    logic [ValWidth-1:0] slot_val[MaxEntriesDefault];
    bit                  slot_ok[MaxEntriesDefault];
    lkv_rsp_t            pending_rsps[$];
    int unsigned         n_get, n_put, n_hit;

    function new();
      capacity = CapReset;
      for (int i = 0; i < MaxEntriesDefault; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
        slot_ok[i]  = 1'b0;
      end
      n_get = 0;
      n_put = 0;
      n_hit = 0;
    endfunction

    function int unsigned live_slots();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > MaxEntriesDefault) c = MaxEntriesDefault;
      return c;
    endfunction

    function void age_slots(int unsigned top);
      for (int unsigned i = top; i > 0; i--) begin
        slot_key[i] = slot_key[i-1];
        slot_val[i] = slot_val[i-1];
        slot_ok[i]  = slot_ok[i-1];
      end
    endfunction

    function void note_request(lkv_req_t req);
      int unsigned         lim;
      int unsigned         hit;
      bit                  hit_ok;
      logic [ValWidth-1:0] v;
      lkv_rsp_t            rsp;
      lim = live_slots();
      for (int unsigned i = lim; i < MaxEntriesDefault; i++) slot_ok[i] = 1'b0;
      hit_ok = 1'b0;
      hit    = 0;
      for (int unsigned i = 0; i < lim; i++) begin
        if (!hit_ok && slot_ok[i] && slot_key[i] == req.key) begin
          hit    = i;
          hit_ok = 1'b1;
        end
      end
      rsp.found      = hit_ok;
      rsp.read_value = '0;
      if (req.cmd == CmdPut) n_put++;
      else n_get++;
      if (hit_ok) begin
        n_hit++;
        v = slot_val[hit];
        if (req.cmd == CmdPut) v = req.value;
        else rsp.read_value = v;
        age_slots(hit);
        slot_key[0] = req.key;
        slot_val[0] = v;
        slot_ok[0]  = 1'b1;
      end else if (req.cmd == CmdPut) begin
        // the entry pushed past the live capacity falls off
        age_slots(lim - 1);
        slot_key[0] = req.key;
        slot_val[0] = req.value;
        slot_ok[0]  = 1'b1;
      end
      pending_rsps.push_back(rsp);
    endfunction

    function bit check_response(lkv_rsp_t got, output string why);
      lkv_rsp_t want;
      why = "";
      if (pending_rsps.size() == 0) begin
        why = "response with no request pending";
        return 1'b0;
      end
      want = pending_rsps.pop_front();
      if (got.found !== want.found)
        why = $sformatf("found %0b, want %0b;", got.found, want.found);
      if (got.read_value !== want.read_value)
        why = {why, $sformatf(" read_value %h, want %h", got.read_value, want.read_value)};
      return why == "";
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lkv_req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lkv_rsp_t out_rsp_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ApbAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lru_shadow shadow = new();
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned cfg_writes = 0;
  bit long_hold = 1'b0;
  bit hold_active = 1'b0;
  logic [KeyWidth-1:0] key_pool[PoolMax];
  int unsigned pool_len = 1;

  lru_key_value_cache DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : monitor
    string why;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (!shadow.check_response(out_rsp_o, why)) report_mismatch(why);
      end
      if (in_valid_i && !in_stall_o) shadow.note_request(in_req_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall segments, plus one long hold-off on request.
  initial begin : receiver
    int unsigned mode;
    int unsigned seg;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active = 1'b0;
        long_hold   = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 120);
        for (int unsigned i = 0; i < seg && !long_hold; i++) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ~out_stall_i;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic apb_write(int unsigned index, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrWidth'(4 * index);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (index == RegCapacity) shadow.capacity = data[CapWidth-1:0];
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_capacity_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrWidth'(4 * RegCapacity);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(32-CapWidth){1'b0}}, shadow.capacity})
      report_mismatch($sformatf("capacity reads %h, want %h", prdata, shadow.capacity));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // all responses back, then wait for the pipeline to go quiet
  task automatic drain();
    while (shadow.pending_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_one(lkv_req_t req);
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic lkv_req_t mk(logic cmd, logic [KeyWidth-1:0] key,
                                  logic [ValWidth-1:0] val);
    lkv_req_t r;
    r.cmd   = cmd;
    r.key   = key;
    r.value = val;
    return r;
  endfunction

  // key pool a little larger than the live capacity, so hits and evictions mix
  task automatic fill_pool();
    pool_len = shadow.live_slots() + 1 + $urandom_range(0, 4);
    if (pool_len > PoolMax) pool_len = PoolMax;
    for (int i = 0; i < PoolMax; i++) begin
      case ($urandom_range(0, 9))
        0: key_pool[i] = '0;
        1: key_pool[i] = '1;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic lkv_req_t random_request();
    lkv_req_t r;
    r.cmd = $urandom_range(0, 1) ? CmdPut : CmdGet;
    if ($urandom_range(0, 9) < 8) r.key = key_pool[$urandom_range(0, pool_len - 1)];
    else r.key = $urandom;
    case ($urandom_range(0, 7))
      0: r.value = '0;
      1: r.value = '1;
      default: r.value = ValWidth'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_phase(int unsigned n, bit gappy);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 10);
      for (int unsigned j = 0; j < burst && sent < n; j++) begin
        send_one(random_request());
        sent++;
      end
      gap = gappy ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : main
    logic [CapWidth-1:0] phase_caps[NumPhases];
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd8, 5'd2, 5'd17, 5'd3, 5'd12};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, hit, miss, update at reset capacity
    send_one(mk(CmdGet, 32'h0000_0000, 31'h0));
    send_one(mk(CmdPut, 32'h0000_0000, 31'h0));
    send_one(mk(CmdGet, 32'h0000_0000, 31'h1234));
    send_one(mk(CmdPut, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    send_one(mk(CmdGet, 32'hFFFF_FFFF, 31'h0));
    send_one(mk(CmdPut, 32'h0000_0000, 31'h7FFF_FFFF));
    send_one(mk(CmdGet, 32'h0000_0000, 31'h0));
    send_one(mk(CmdPut, 32'h5555_5555, 31'h2AAA_AAAA));
    send_one(mk(CmdPut, 32'hAAAA_AAAA, 31'h5555_5555));
    send_one(mk(CmdGet, 32'hAAAA_AAAA, 31'h7FFF_FFFF));
    send_one(mk(CmdGet, 32'h5555_5555, 31'h0));
    in_valid_i <= 1'b0;
    drain();
    check_capacity_reg();

    // lowering capacity with entries held drops the oldest ones
    apb_write(RegCapacity, 32'd2);
    send_one(mk(CmdGet, 32'h0000_0000, 31'h0));
    send_one(mk(CmdGet, 32'hFFFF_FFFF, 31'h0));
    send_one(mk(CmdPut, 32'h0000_0001, 31'h1));
    send_one(mk(CmdGet, 32'hAAAA_AAAA, 31'h0));
    send_one(mk(CmdGet, 32'h5555_5555, 31'h0));
    in_valid_i <= 1'b0;
    drain();

    // zero capacity behaves as one entry
    apb_write(RegCapacity, 32'd0);
    send_one(mk(CmdPut, 32'h0000_0002, 31'h2));
    send_one(mk(CmdPut, 32'h0000_0003, 31'h3));
    send_one(mk(CmdGet, 32'h0000_0002, 31'h0));
    send_one(mk(CmdGet, 32'h0000_0003, 31'h0));
    in_valid_i <= 1'b0;
    drain();
    apb_write(RegUnused, 32'd7);
    check_capacity_reg();

    // oversized capacity saturates; raising keeps what is held
    apb_write(RegCapacity, 32'd31);
    check_capacity_reg();
    send_one(mk(CmdGet, 32'h0000_0003, 31'h0));
    send_one(mk(CmdPut, 32'h0000_0004, 31'h4));
    send_one(mk(CmdGet, 32'h0000_0003, 31'h0));
    in_valid_i <= 1'b0;
    drain();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      apb_write(RegCapacity, {{(32-CapWidth){1'b0}}, phase_caps[p]});
      fill_pool();
      if (p == 2) begin
        long_hold = 1'b1;
        wait (hold_active);
        @(posedge clk_i);
      end
      send_phase(PhaseItems, (p % 3) != 0);
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d requests: %0d gets, %0d puts, %0d hits", shadow.n_get + shadow.n_put,
             shadow.n_get, shadow.n_put, shadow.n_hit);
    $display("%0d register writes, capacity from 0 to 31, one long output hold-off",
             cfg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
